// File: rtl/core/cskd_pkg.sv
// ----------------------------------------------------------------------------
// cskd_pkg: shared types and constants for the curve slope knee detector
// Widths of the point fields, register indexes, status codes and the
// controller state type.
// ----------------------------------------------------------------------------
package cskd_pkg;

    // point field widths (signed fixed point, 8 fraction bits)
    localparam int DATA_W = 24;
    // one step change: difference of two points
    localparam int STEP_W = DATA_W + 1;
    localparam int RATIO_W = 8;
    // ratio times the first-half sum (unsigned ratio made signed)
    localparam int RHS_W = STEP_W + RATIO_W + 1;

    localparam int DEF_MAX_POINTS = 128;
    localparam int MIN_POINTS = 4;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = RATIO_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATIO = 1'b1;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd10;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_NONE     = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SUM0,
        S_SUM1,
        S_SUM2,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

// File: rtl/core/cskd_curve_mem.sv
// ----------------------------------------------------------------------------
// cskd_curve_mem: point storage
// Two synchronous memories (flow and sample) sharing one write address and
// one read address; read data is registered.
// ----------------------------------------------------------------------------
module cskd_curve_mem #(
    parameter int MAX_POINTS = cskd_pkg::DEF_MAX_POINTS
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_waddr,
    input  logic signed [cskd_pkg::DATA_W-1:0]  i_wflow,
    input  logic signed [cskd_pkg::DATA_W-1:0]  i_wvalue,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_raddr,
    output logic signed [cskd_pkg::DATA_W-1:0]  o_rflow,
    output logic signed [cskd_pkg::DATA_W-1:0]  o_rvalue
);
    import cskd_pkg::*;

    logic signed [DATA_W-1:0] flow_mem  [MAX_POINTS];
    logic signed [DATA_W-1:0] value_mem [MAX_POINTS];

    // write one point
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            flow_mem[i_waddr]  <= i_wflow;
            value_mem[i_waddr] <= i_wvalue;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rflow  <= flow_mem[i_raddr];
        o_rvalue <= value_mem[i_raddr];
    end

endmodule

// File: rtl/core/curve_slope_knee_detector.sv
// ----------------------------------------------------------------------------
// curve_slope_knee_detector: knee search over one stored pump curve
// Stores points one per beat; on the last point compares each second-half
// step against ratio times the mean first-half step by cross-multiplying.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        i_in_valid / o_in_ready, flow/sample/last  into block
//  out       o_out_valid / i_out_ready, status/knee     out of block
//  cfg       i_cfg_we, i_cfg_addr, i_cfg_wdata          into block, no wait
//
//  A point beat that is not last is a single memory write.
//  After the last beat the block reads point 0 and point n/2-1 (the first
//  half sum telescopes), then streams reads n/2 .. n-1 through a three-deep
//  step/multiply/compare pipe. A short or overflowed curve skips the scan
//  and goes straight to the emit state. Input ready is low from the last
//  beat until the result is loaded into the output register.
//  A staged result waits in the output register while new points load.
//  Reset is synchronous and active low; the memories are not cleared.
// ----------------------------------------------------------------------------
module curve_slope_knee_detector #(
    parameter int MAX_POINTS = cskd_pkg::DEF_MAX_POINTS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config
    input  logic                                  i_cfg_we,
    input  logic [cskd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [cskd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // input points
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [cskd_pkg::DATA_W-1:0]    i_flow_rate,
    input  logic signed [cskd_pkg::DATA_W-1:0]    i_sample_value,
    input  logic                                  i_last_point,
    // results
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic signed [cskd_pkg::DATA_W-1:0]    o_knee_flow,
    output logic signed [cskd_pkg::DATA_W-1:0]    o_knee_value
);
    import cskd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int M_W    = CNT_W - 1;
    localparam int LHS_W  = STEP_W + M_W + 1;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // state and control
    t_state                   r_state, n_state;
    logic                     r_direction;
    logic [RATIO_W-1:0]       r_ratio;
    logic [CNT_W-1:0]         r_count;
    logic                     r_overflow;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_half;
    logic [M_W-1:0]           r_m;
    logic [CNT_W-1:0]         r_rd_idx;
    logic                     r_s1_vld;
    logic                     r_s1_first;
    logic                     r_s2_vld;
    logic signed [DATA_W-1:0] r_last_flow;

    // analysis datapath
    logic signed [DATA_W-1:0] r_v0;
    logic signed [DATA_W-1:0] r_prev;
    logic signed [STEP_W-1:0] r_sum;
    logic signed [RHS_W-1:0]  r_rhs;
    logic signed [LHS_W-1:0]  r_lhs;
    logic signed [DATA_W-1:0] r_s2_flow;
    logic signed [DATA_W-1:0] r_s2_value;

    // staged and delivered result
    t_status                  r_res_status;
    logic signed [DATA_W-1:0] r_res_flow;
    logic signed [DATA_W-1:0] r_res_value;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic signed [DATA_W-1:0] r_out_flow;
    logic signed [DATA_W-1:0] r_out_value;

    // combinational
    logic                     in_fire;
    logic                     wr_point;
    logic [CNT_W-1:0]         n_count_new;
    logic                     ovf_new;
    logic [ADDR_W-1:0]        mem_raddr;
    logic                     scan_issue;
    logic                     scan_found;
    logic                     scan_done;
    logic                     out_free;
    logic signed [DATA_W-1:0] rd_flow;
    logic signed [DATA_W-1:0] rd_value;
    logic signed [STEP_W-1:0] step_d;
    logic signed [STEP_W-1:0] sum_d;
    logic signed [CMP_W-1:0]  lhs_ext;
    logic signed [CMP_W-1:0]  rhs_ext;

    // point storage
    cskd_curve_mem #(
        .MAX_POINTS (MAX_POINTS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (wr_point),
        .i_waddr  (r_count[ADDR_W-1:0]),
        .i_wflow  (i_flow_rate),
        .i_wvalue (i_sample_value),
        .i_raddr  (mem_raddr),
        .o_rflow  (rd_flow),
        .o_rvalue (rd_value)
    );

    // accept bookkeeping; writes only happen in load, read data is used only in analysis
    assign in_fire     = i_in_valid && o_in_ready;
    assign wr_point    = in_fire && (r_count != CNT_W'(MAX_POINTS));
    assign n_count_new = wr_point ? (r_count + CNT_W'(1)) : r_count;
    assign ovf_new     = r_overflow || (in_fire && !wr_point);
    assign out_free    = !r_out_valid || i_out_ready;

    // step, sum and compare arithmetic
    assign step_d = r_direction ? (STEP_W'(rd_value) - STEP_W'(r_prev))
                                : (STEP_W'(r_prev) - STEP_W'(rd_value));
    assign sum_d  = r_direction ? (STEP_W'(rd_value) - STEP_W'(r_v0))
                                : (STEP_W'(r_v0) - STEP_W'(rd_value));
    assign lhs_ext    = CMP_W'(r_lhs);
    assign rhs_ext    = CMP_W'(r_rhs);
    assign scan_found = r_s2_vld && (lhs_ext > rhs_ext);
    assign scan_done  = !scan_issue && !r_s1_vld && !r_s2_vld;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_fire && i_last_point) begin
                    if (ovf_new || (n_count_new < CNT_W'(MIN_POINTS))) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SUM0;
                    end
                end
            end
            S_SUM0: n_state = S_SUM1;
            S_SUM1: n_state = S_SUM2;
            S_SUM2: n_state = S_SCAN;
            S_SCAN: begin
                if (scan_found || scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        scan_issue = 1'b0;
        mem_raddr  = r_rd_idx[ADDR_W-1:0];
        case (r_state)
            S_LOAD: o_in_ready = 1'b1;
            S_SUM0: mem_raddr = '0;
            S_SUM1: mem_raddr = ADDR_W'(r_m);
            S_SCAN: scan_issue = (r_rd_idx != r_n);
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_direction <= 1'b0;
            r_ratio     <= RATIO_RESET;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // config writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DIRECTION: r_direction <= i_cfg_wdata[0];
                    CFG_RATIO:     r_ratio     <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // count points; clear the curve on the last beat
            if (in_fire) begin
                if (i_last_point) begin
                    r_count    <= '0;
                    r_overflow <= 1'b0;
                end else begin
                    r_count    <= n_count_new;
                    r_overflow <= ovf_new;
                end
            end

            // scan pipe valids; drop anything in flight once finished
            if (r_state == S_SCAN && !(scan_found || scan_done)) begin
                r_s1_vld <= scan_issue;
                r_s2_vld <= r_s1_vld && !r_s1_first;
            end else begin
                r_s1_vld <= 1'b0;
                r_s2_vld <= 1'b0;
            end

            // output register
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // analysis datapath
    always_ff @(posedge i_clk) begin
        if (wr_point) begin
            r_last_flow <= i_flow_rate;
        end

        // latch curve size and stage early results
        if (in_fire && i_last_point) begin
            r_n    <= n_count_new;
            r_half <= n_count_new >> 1;
            r_m    <= M_W'((n_count_new >> 1) - CNT_W'(1));
            r_res_flow  <= '0;
            r_res_value <= '0;
            r_res_status <= ovf_new ? ST_OVERFLOW : ST_SHORT;
        end

        // first-half sum telescopes to the end points of the half
        if (r_state == S_SUM1) begin
            r_v0 <= rd_value;
        end
        if (r_state == S_SUM2) begin
            r_sum    <= sum_d;
            r_rd_idx <= r_half;
        end

        // scan pipe: issue, step and multiply, compare
        if (r_state == S_SCAN) begin
            r_rhs <= RHS_W'($signed({1'b0, r_ratio}) * r_sum);
            if (scan_issue) begin
                r_rd_idx   <= r_rd_idx + CNT_W'(1);
                r_s1_first <= (r_rd_idx == r_half);
            end
            if (r_s1_vld) begin
                r_prev     <= rd_value;
                r_lhs      <= LHS_W'(step_d * $signed({1'b0, r_m}));
                r_s2_flow  <= rd_flow;
                r_s2_value <= rd_value;
            end
            if (scan_found) begin
                r_res_status <= ST_FOUND;
                r_res_flow   <= r_s2_flow;
                r_res_value  <= r_s2_value;
            end else if (scan_done) begin
                r_res_status <= ST_NONE;
                r_res_flow   <= r_last_flow;
                r_res_value  <= '0;
            end
        end

        // load the output register
        if (r_state == S_EMIT && out_free) begin
            r_out_status <= r_res_status;
            r_out_flow   <= r_res_flow;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_knee_flow  = r_out_flow;
    assign o_knee_value = r_out_value;

    // checks
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last_point) |=> (r_count == '0) && !r_overflow)
        else $error("curve not cleared after last point");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= r_n))
        else $error("scan read past last stored point");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_status != ST_FOUND)) |-> (o_knee_value == '0))
        else $error("knee value set without a knee");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for curve_slope_knee_detector
// Sends pump curves point by point with random gaps and output stalls,
// predicts each knee result from a local copy of the stored curve and checks
// every result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
    import cskd_pkg::*;

    localparam int NUM_POINTS     = DEF_MAX_POINTS;
    localparam int RANDOM_ITEMS   = 950;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = NUM_POINTS;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] flow;
        logic signed [DATA_W-1:0] value;
    } t_knee_result;

    // DUT side signals
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr  = CFG_DIRECTION;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic signed [DATA_W-1:0] in_flow   = '0;
    logic signed [DATA_W-1:0] in_sample = '0;
    logic                     in_last   = 1'b0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic [1:0]               out_status;
    logic signed [DATA_W-1:0] out_flow;
    logic signed [DATA_W-1:0] out_value;

    // local copy of the curve and the registers
    logic signed [DATA_W-1:0] curve_flow   [NUM_POINTS];
    logic signed [DATA_W-1:0] curve_sample [NUM_POINTS];
    int unsigned              curve_len     = 0;
    bit                       curve_dropped = 1'b0;
    bit                       rise_mode     = 1'b0;
    logic [RATIO_W-1:0]       ratio         = RATIO_RESET;

    t_knee_result pending_knees[$];
    int           fail_count  = 0;
    int           idle_cycles = 0;
    bit           idle_on     = 1'b0;
    bit           stall_on    = 1'b0;

    curve_slope_knee_detector u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_flow_rate    (in_flow),
        .i_sample_value (in_sample),
        .i_last_point   (in_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (out_status),
        .o_knee_flow    (out_flow),
        .o_knee_value   (out_value)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // step change between point i and i+1, signed by the direction mode
    function automatic longint step_change_at(int unsigned i);
        longint a;
        longint b;
        a = longint'(curve_sample[i]);
        b = longint'(curve_sample[i + 1]);
        return rise_mode ? (b - a) : (a - b);
    endfunction

    // store one accepted point; on the last one, work out the knee result
    function automatic void analyze_curve_point(logic signed [DATA_W-1:0] flow,
                                                logic signed [DATA_W-1:0] sample,
                                                logic last);
        t_knee_result r;
        int unsigned  half;
        int unsigned  m;
        longint       sum;
        longint       rhs;
        bit           found;
        if (curve_len < NUM_POINTS) begin
            curve_flow[curve_len]   = flow;
            curve_sample[curve_len] = sample;
            curve_len++;
        end else begin
            curve_dropped = 1'b1;
        end
        if (!last) return;

        r.status = ST_NONE;
        r.flow   = '0;
        r.value  = '0;
        if (curve_dropped) begin
            r.status = ST_OVERFLOW;
        end else if (curve_len < MIN_POINTS) begin
            r.status = ST_SHORT;
        end else begin
            half  = curve_len / 2;
            m     = half - 1;
            sum   = 0;
            found = 1'b0;
            for (int unsigned i = 0; i < m; i++) sum += step_change_at(i);
            rhs = longint'(ratio) * sum;
            // first second-half step above ratio times the mean, no division
            for (int unsigned i = half; i + 1 < curve_len && !found; i++) begin
                if (step_change_at(i) * longint'(m) > rhs) begin
                    found    = 1'b1;
                    r.status = ST_FOUND;
                    r.flow   = curve_flow[i + 1];
                    r.value  = curve_sample[i + 1];
                end
            end
            if (!found) r.flow = curve_flow[curve_len - 1];
        end
        pending_knees.push_back(r);
        curve_len     = 0;
        curve_dropped = 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = int'($urandom_range(99));
        if (r < 70) return 0;
        if (r < 95) return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 30));
    endfunction

    // send one point beat and hand it to the predictor once accepted
    task automatic send_point(input logic signed [DATA_W-1:0] flow,
                              input logic signed [DATA_W-1:0] sample,
                              input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_flow   <= flow;
        in_sample <= sample;
        in_last   <= last;
        do @(posedge clk); while (!in_ready);
        analyze_curve_point(flow, sample, last);
    endtask

    // hold the sender until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_knees.size() != 0);
    endtask

    // write both registers while the block is idle
    task automatic write_settings(input bit rise, input logic [RATIO_W-1:0] r);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DIRECTION;
        cfg_wdata <= CFG_DATA_W'(rise);
        @(posedge clk);
        cfg_addr  <= CFG_RATIO;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rise_mode = rise;
        ratio     = r;
    endtask

    // one curve: either a shaped curve (flat-ish first half, optional knee
    // near the threshold in the second half) or full-range noise
    task automatic send_shaped_curve(input int len, input bit shaped);
        logic signed [DATA_W-1:0] flow;
        logic signed [DATA_W-1:0] sample;
        int  avg_step;
        int  half;
        int  knee_at;
        int  d;
        bit  has_knee;
        half     = len / 2;
        avg_step = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(1, 20));
        has_knee = (len >= MIN_POINTS) && ($urandom_range(99) < 65);
        knee_at  = (len >= MIN_POINTS) ? int'($urandom_range(half, len - 2)) : 0;
        flow     = DATA_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        sample   = DATA_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        for (int p = 0; p < len; p++) begin
            if (!shaped) begin
                flow   = DATA_W'($urandom());
                sample = DATA_W'($urandom());
            end
            send_point(flow, sample, p == len - 1);
            // step from point p to p+1
            if (p + 1 < half) begin
                d = avg_step;
            end else if (has_knee && p == knee_at) begin
                d = int'(ratio) * avg_step;
                case ($urandom_range(3))
                    0:       d = d - 1;
                    1:       d = d;
                    2:       d = d + 1;
                    default: d = d + int'($urandom_range(2, 5000));
                endcase
            end else begin
                d = int'($urandom_range(0, avg_step));
            end
            sample = DATA_W'(rise_mode ? int'(sample) + d : int'(sample) - d);
            flow   = DATA_W'(int'(flow) + int'($urandom_range(1, 2000)));
        end
    endtask

    // reset values first, then short curves, extremes, threshold edge, ratio zero
    task automatic test_directed_curves();
        send_point(DATA_MAX, DATA_MIN, 1'b1);
        send_point(DATA_MIN, '0, 1'b0);
        send_point('0, DATA_MAX, 1'b0);
        send_point(DATA_MAX, -24'sd1, 1'b1);
        // knee at the only scanned step
        send_point(24'sd256, 24'sd100, 1'b0);
        send_point(24'sd512, 24'sd99, 1'b0);
        send_point(24'sd768, 24'sd98, 1'b0);
        send_point(24'sd1024, 24'sd50, 1'b1);
        // full-scale drop at the extremes of both fields
        send_point(DATA_MIN, DATA_MAX, 1'b0);
        send_point(-24'sd1, DATA_MAX, 1'b0);
        send_point(24'sd1, DATA_MAX, 1'b0);
        send_point(DATA_MAX, DATA_MIN, 1'b1);

        write_settings(1'b1, 8'd255);
        send_point(24'sd10, 24'sd0, 1'b0);
        send_point(24'sd20, 24'sd1, 1'b0);
        send_point(24'sd30, 24'sd2, 1'b0);
        send_point(24'sd40, 24'sd3, 1'b1);
        // step equal to ratio times mean: not a knee
        send_point(24'sd10, 24'sd0, 1'b0);
        send_point(24'sd20, 24'sd1, 1'b0);
        send_point(24'sd30, 24'sd1, 1'b0);
        send_point(24'sd40, 24'sd256, 1'b1);

        // ratio zero: any positive step counts
        write_settings(1'b0, 8'd0);
        send_point(24'sd5, 24'sd0, 1'b0);
        send_point(24'sd6, 24'sd5, 1'b0);
        send_point(24'sd7, 24'sd5, 1'b0);
        send_point(24'sd8, 24'sd4, 1'b1);
    endtask

    // full store, dropped points, then a normal curve to see the clear
    task automatic test_store_overflow();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        write_settings(1'b1, 8'd1);
        send_shaped_curve(NUM_POINTS, 1'b1);
        send_shaped_curve(NUM_POINTS + 3, 1'b1);
        send_shaped_curve(5, 1'b1);
    endtask

    task automatic test_random_curves();
        int items;
        int curves;
        int r;
        int len;
        logic [RATIO_W-1:0] new_ratio;
        items  = 0;
        curves = 0;
        while (items < RANDOM_ITEMS) begin
            if (curves % 12 == 0) begin
                r = int'($urandom_range(9));
                if (r == 0) new_ratio = 8'd1;
                else if (r == 1) new_ratio = 8'd255;
                else new_ratio = RATIO_W'($urandom_range(2, 40));
                write_settings(1'($urandom_range(1)), new_ratio);
            end
            idle_on  = ($urandom_range(3) != 0);
            stall_on = ($urandom_range(3) != 0);
            r = int'($urandom_range(99));
            if (r < 10) len = int'($urandom_range(1, 3));
            else if (r < 80) len = int'($urandom_range(4, 16));
            else if (r < 96) len = int'($urandom_range(17, 60));
            else if (r < 98) len = int'($urandom_range(100, NUM_POINTS));
            else len = int'($urandom_range(NUM_POINTS + 1, NUM_POINTS + 4));
            send_shaped_curve(len, $urandom_range(99) < 80);
            items += len;
            curves++;
            if ($urandom_range(9) == 0) drain_results();
        end
    endtask

    // result side: stretches of ready, with or without stalls
    initial begin
        int  len;
        bit  level;
        forever begin
            if (!stall_on) begin
                level = 1'b1;
                len   = int'($urandom_range(1, 16));
            end else begin
                level = ($urandom_range(99) < 65);
                if (level) len = int'($urandom_range(1, 8));
                else if ($urandom_range(9) == 0) len = int'($urandom_range(10, 40));
                else len = int'($urandom_range(1, 3));
            end
            out_ready <= level;
            repeat (len) @(posedge clk);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk) begin
        t_knee_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_knees.size() == 0) begin
                log_failure($sformatf("unexpected result status=%0d flow=%0d value=%0d",
                                      out_status, out_flow, out_value));
            end else begin
                want = pending_knees.pop_front();
                if (out_status !== want.status || out_flow !== want.flow ||
                    out_value !== want.value) begin
                    log_failure($sformatf(
                        "exp status=%0d flow=%0d value=%0d, got status=%0d flow=%0d value=%0d",
                        want.status, want.flow, want.value,
                        out_status, out_flow, out_value));
                end
            end
        end
    end

    // end the run when nothing moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_curves();
        test_store_overflow();
        test_random_curves();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_knees.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
